[design/granule_block_encrypt_assert.svh]
// Assertion macros shared by the granule block encrypt RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef GRANULE_BLOCK_ENCRYPT_ASSERT_SVH
`define GRANULE_BLOCK_ENCRYPT_ASSERT_SVH

`ifndef SYNTHESIS
// General clocked property with a synchronous reset that disables it.
`define GBE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Antecedent in this cycle implies the consequent in the next cycle.
`define GBE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GBE_ASSERT(name, clk, rst, prop, msg)
`define GBE_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[design/gbe_pkg.sv]
// Shared types, constants and round functions of the granule block encrypt core.
// Used by gbe_csr, gbe_round and granule_block_encrypt; no dependencies.
package gbe_pkg;

   localparam int ROUND_COUNT_DEF = 32;
   localparam int ROUND_IDX_WIDTH = 5;
   localparam int HALF_WIDTH      = 32;
   localparam int BLOCK_WIDTH     = 64;
   localparam int KEY_WIDTH       = 128;
   localparam int REG_WIDTH       = 64;

   // Register map: 64-bit registers at byte addresses 0 and 8.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int REG_SEL_BIT    = 3;
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   localparam logic [REG_WIDTH-1:0] KEY_LOW_RESET  = 64'hfedc_ba98_7654_3210;
   localparam logic [REG_WIDTH-1:0] KEY_HIGH_RESET = 64'h0123_4567_89ab_cdee;

   localparam logic [3:0] SBOX [16] = '{
      4'd14, 4'd7, 4'd8, 4'd4, 4'd1, 4'd9, 4'd2, 4'd15,
      4'd5, 4'd10, 4'd11, 4'd0, 4'd6, 4'd12, 4'd13, 4'd3
   };
   localparam logic [2:0] PERM [8] = '{3'd4, 3'd0, 3'd3, 3'd1, 3'd6, 3'd2, 3'd7, 3'd5};

   localparam int KEY_ROT = 31;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] half_hi;
      logic [HALF_WIDTH-1:0] half_lo;
      logic [KEY_WIDTH-1:0]  key;
   } stage_type;

   // Nibble permutation, S-box layer and the two rotations of the round function.
   function automatic logic [HALF_WIDTH-1:0] round_fn(input logic [HALF_WIDTH-1:0] hi);
      logic [3:0]            moved [8];
      logic [HALF_WIDTH-1:0] w;
      for (int i = 0; i < 8; i++) begin
         moved[PERM[i]] = hi[4*i +: 4];
      end
      for (int j = 0; j < 8; j++) begin
         w[4*j +: 4] = SBOX[moved[j]];
      end
      return {w[HALF_WIDTH-3:0], w[HALF_WIDTH-1:HALF_WIDTH-2]} ^
             {w[6:0], w[HALF_WIDTH-1:7]};
   endfunction

   // One key schedule update: rotate left by 31, substitute the two low
   // nibbles, then fold the round number into the upper word.
   function automatic logic [KEY_WIDTH-1:0] key_step(input logic [KEY_WIDTH-1:0] key,
                                                      input logic [ROUND_IDX_WIDTH-1:0] rnd);
      logic [KEY_WIDTH-1:0] r;
      r = {key[KEY_WIDTH-1-KEY_ROT:0], key[KEY_WIDTH-1:KEY_WIDTH-KEY_ROT]};
      r[3:0] = SBOX[r[3:0]];
      r[7:4] = SBOX[r[7:4]];
      r[REG_WIDTH +: REG_WIDTH] = r[REG_WIDTH +: REG_WIDTH] ^
                                  {{(REG_WIDTH-ROUND_IDX_WIDTH-2){1'b0}}, rnd, 2'b00};
      return r;
   endfunction

endpackage

[design/gbe_csr.sv]
// Key register file with an APB-style access port.
// Depends on gbe_pkg for the register map and reset values.
module gbe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gbe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [gbe_pkg::REG_WIDTH-1:0]      csr_pwdata,
   output logic [gbe_pkg::REG_WIDTH-1:0]      csr_prdata,
   output logic                              csr_pready,
   output logic [gbe_pkg::REG_WIDTH-1:0]      key_low,
   output logic [gbe_pkg::REG_WIDTH-1:0]      key_high
);
   import gbe_pkg::*;

   logic [REG_WIDTH-1:0] key_low_ff, key_low_in;
   logic [REG_WIDTH-1:0] key_high_ff, key_high_in;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (wr_en) begin
         unique case (csr_paddr[REG_SEL_BIT])
            REG_KEY_LOW:  key_low_in  = csr_pwdata;
            REG_KEY_HIGH: key_high_in = csr_pwdata;
            default:      key_low_in  = key_low_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[REG_SEL_BIT])
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KEY_LOW_RESET;
         key_high_ff <= KEY_HIGH_RESET;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   assign key_low  = key_low_ff;
   assign key_high = key_high_ff;

endmodule

[design/gbe_round.sv]
// One registered cipher round with its key schedule update and stall control.
// Depends on gbe_pkg and the assertion macros in granule_block_encrypt_assert.svh.
`include "granule_block_encrypt_assert.svh"

module gbe_round #(
   parameter int ROUND_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gbe_pkg::stage_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output gbe_pkg::stage_type out_data
);
   import gbe_pkg::*;

   localparam logic [ROUND_IDX_WIDTH-1:0] RND = ROUND_IDX_WIDTH'(ROUND_IDX);

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;
   logic      load;

   // The stage takes a new item whenever it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      data_in.half_hi = in_data.half_lo ^ round_fn(in_data.half_hi) ^
                        in_data.key[HALF_WIDTH-1:0];
      data_in.half_lo = in_data.half_hi;
      data_in.key     = key_step(in_data.key, RND);
      valid_in        = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `GBE_ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff && !out_ready, valid_ff && $stable(data_ff), "stalled stage lost or changed its item")
   `GBE_ASSERT_NEXT(a_load_fills, clock, reset, load, valid_ff, "loaded item did not appear in stage")
   `GBE_ASSERT_NEXT(a_drain_empties, clock, reset, valid_ff && out_ready && !in_valid, !valid_ff, "drained stage still shows an item")

endmodule

[design/granule_block_encrypt.sv]
// Top level of the granule block encrypt core: key registers and round pipeline.
// Depends on gbe_pkg, gbe_csr and gbe_round.
//
// This core encrypts 64-bit blocks with a 64/128 Feistel block cipher whose
// 128-bit key sits in two 64-bit registers (key_low at byte address 0, key_high
// at byte address 8). Each of the ROUND_COUNT rounds is its own register stage,
// and the key schedule travels down the pipeline beside the block, so one block
// can be accepted every cycle while the output side does not stall. One round
// plus one schedule update lies between any two registers. Every stage has its
// own valid bit and moves on when the next stage is empty or moving, so a stall
// on the result channel fills bubbles first and the input is refused only when
// every stage holds a block; no transfer is lost or repeated. The key registers
// should be written only while no block is in flight, since every stage reads
// the key when the block enters. The last stage register drives the result
// channel directly.
module granule_block_encrypt #(
   parameter int ROUND_COUNT = gbe_pkg::ROUND_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gbe_pkg::BLOCK_WIDTH-1:0]    req_tdata,   // [63:0] plaintext
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gbe_pkg::BLOCK_WIDTH-1:0]    rsp_tdata,   // [63:0] ciphertext
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gbe_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [gbe_pkg::REG_WIDTH-1:0]      csr_pwdata,
   output logic [gbe_pkg::REG_WIDTH-1:0]      csr_prdata,
   output logic                               csr_pready
);
   import gbe_pkg::*;

   logic [REG_WIDTH-1:0] key_low;
   logic [REG_WIDTH-1:0] key_high;

   // Link i feeds round stage i; the last link is the result channel.
   stage_type link_data  [ROUND_COUNT+1];
   logic      link_valid [ROUND_COUNT+1];
   logic      link_ready [ROUND_COUNT+1];

   gbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_low     (key_low),
      .key_high    (key_high)
   );

   // The plaintext splits into the high and low Feistel halves, and the block
   // picks up its own copy of the key as it enters the first round.
   always_comb begin
      link_data[0].half_hi = req_tdata[BLOCK_WIDTH-1:HALF_WIDTH];
      link_data[0].half_lo = req_tdata[HALF_WIDTH-1:0];
      link_data[0].key     = {key_high, key_low};
   end
   assign link_valid[0] = req_tvalid;
   assign req_tready    = link_ready[0];

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
      gbe_round #(
         .ROUND_IDX (g)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   // The key that leaves the final stage is never used and is trimmed away.
   assign rsp_tvalid                = link_valid[ROUND_COUNT];
   assign link_ready[ROUND_COUNT]   = rsp_tready;
   assign rsp_tdata = {link_data[ROUND_COUNT].half_hi, link_data[ROUND_COUNT].half_lo};

endmodule

[test/granule_block_encrypt_test.sv]
// Self-checking testbench for granule_block_encrypt: 64-bit block encryption under a key
// held in two 64-bit registers. Depends on gbe_pkg and the granule_block_encrypt RTL.
`timescale 1ns / 1ps

module granule_block_encrypt_test;

   import gbe_pkg::*;

   // Cipher constants, kept here so that the expected values do not lean on the RTL.
   localparam int        ROUNDS = ROUND_COUNT_DEF;
   localparam bit [3:0]  NIBBLE_SUB [16] = '{
      4'd14, 4'd7, 4'd8, 4'd4, 4'd1, 4'd9, 4'd2, 4'd15,
      4'd5, 4'd10, 4'd11, 4'd0, 4'd6, 4'd12, 4'd13, 4'd3
   };
   localparam bit [2:0]  NIBBLE_DEST [8] = '{3'd4, 3'd0, 3'd3, 3'd1, 3'd6, 3'd2, 3'd7, 3'd5};

   // Byte addresses of the two key registers; the register select sits at REG_SEL_BIT.
   localparam logic [CSR_ADDR_WIDTH-1:0] KEY_LOW_ADDR  = CSR_ADDR_WIDTH'(REG_KEY_LOW)
                                                         << REG_SEL_BIT;
   localparam logic [CSR_ADDR_WIDTH-1:0] KEY_HIGH_ADDR = CSR_ADDR_WIDTH'(REG_KEY_HIGH)
                                                         << REG_SEL_BIT;

   // The pipeline is ROUNDS stages deep, so this many quiet cycles after the last
   // result is plenty for anything stray to show up.
   localparam int TAIL_CYCLES  = ROUNDS + 16;
   // No correct run goes this long without a single transfer: the longest quiet
   // stretch is a full pipeline drain behind a stalled receiver.
   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 120;

   // Keeps a copy of the key registers and the ciphertexts still owed by the block.
   class cipher_ledger;
      bit [REG_WIDTH-1:0]   key_low;
      bit [REG_WIDTH-1:0]   key_high;
      bit [BLOCK_WIDTH-1:0] owed_ciphertext [$];
      int                   errors;

      function new();
         key_low  = KEY_LOW_RESET;
         key_high = KEY_HIGH_RESET;
         errors   = 0;
      endfunction

      function void set_key(logic sel, bit [REG_WIDTH-1:0] value);
         if (sel == REG_KEY_LOW) begin
            key_low = value;
         end else begin
            key_high = value;
         end
      endfunction

      // Round function: nibble shuffle, S-box layer, then the two rotations.
      function bit [31:0] mix_half(bit [31:0] hi);
         bit [3:0]  placed [8];
         bit [31:0] w;
         for (int i = 0; i < 8; i++) begin
            placed[NIBBLE_DEST[i]] = hi[4*i +: 4];
         end
         for (int j = 0; j < 8; j++) begin
            w[4*j +: 4] = NIBBLE_SUB[placed[j]];
         end
         return {w[29:0], w[31:30]} ^ {w[6:0], w[31:7]};
      endfunction

      // Key schedule: 128-bit rotate left by 31, substitute the two low nibbles,
      // then fold the round number (shifted by two) into the upper word.
      function bit [127:0] next_key(bit [127:0] k, bit [4:0] rnd);
         bit [127:0] n;
         n = {k[96:0], k[127:97]};
         n[3:0] = NIBBLE_SUB[n[3:0]];
         n[7:4] = NIBBLE_SUB[n[7:4]];
         n[127:64] = n[127:64] ^ {57'd0, rnd, 2'b00};
         return n;
      endfunction

      function bit [BLOCK_WIDTH-1:0] encrypt_block(bit [BLOCK_WIDTH-1:0] plain);
         bit [127:0] k;
         bit [31:0]  hi;
         bit [31:0]  lo;
         bit [31:0]  nh;
         k  = {key_high, key_low};
         hi = plain[63:32];
         lo = plain[31:0];
         for (int r = 0; r < ROUNDS; r++) begin
            nh = lo ^ mix_half(hi);
            lo = hi;
            hi = nh ^ k[31:0];
            // The key after the final round is derived but never used.
            k  = next_key(k, 5'(r));
         end
         return {hi, lo};
      endfunction

      function void note_plaintext(bit [BLOCK_WIDTH-1:0] plain);
         owed_ciphertext.push_back(encrypt_block(plain));
      endfunction

      function void check_ciphertext(bit [BLOCK_WIDTH-1:0] actual);
         bit [BLOCK_WIDTH-1:0] want;
         if (owed_ciphertext.size() == 0) begin
            $error("ciphertext: result transfer with nothing expected, actual %h", actual);
            errors++;
         end else begin
            want = owed_ciphertext.pop_front();
            if (want !== actual) begin
               $error("ciphertext mismatch: expected %h, actual %h", want, actual);
               errors++;
            end
         end
      endfunction

      function int owed();
         return owed_ciphertext.size();
      endfunction
   endclass

   // Clock, reset and every block input start at known values.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [BLOCK_WIDTH-1:0]    req_tdata = '0;    // [63:0] plaintext
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [BLOCK_WIDTH-1:0]    rsp_tdata;         // [63:0] ciphertext
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [REG_WIDTH-1:0]      csr_pwdata = '0;
   logic [REG_WIDTH-1:0]      csr_prdata;
   logic                      csr_pready;

   cipher_ledger ledger = new();

   // When set, the sender or the receiver runs a stretch with no idle cycles at all.
   bit send_steady = 1'b0;
   bit take_steady = 1'b0;

   always #2 clock = ~clock;

   granule_block_encrypt u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Offers one plaintext block after a random gap and returns once the transfer
   // has happened. With a zero gap, valid simply stays high from the last block,
   // so it is never dropped and raised again in the same time step.
   task automatic send_plaintext(input bit [BLOCK_WIDTH-1:0] plain);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= plain;
      do @(posedge clock); while (!req_tready);
      ledger.note_plaintext(plain);
   endtask

   // A setup phase, then the access phase; the register takes the data at the edge
   // where psel, penable, pwrite and pready are all high. The bus then idles before the
   // task returns, so that the next write starts its setup phase in a later time step.
   task automatic write_key(input logic sel, input bit [REG_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= (sel == REG_KEY_LOW) ? KEY_LOW_ADDR : KEY_HIGH_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      ledger.set_key(sel, value);
      @(posedge clock);
   endtask

   // Holds the sender back until every owed ciphertext has come out. Every block
   // yields a result, so an empty ledger also means an empty pipeline.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (ledger.owed() != 0) @(posedge clock);
   endtask

   task automatic load_keys(input bit [REG_WIDTH-1:0] lo, input bit [REG_WIDTH-1:0] hi);
      drain();
      write_key(REG_KEY_LOW, lo);
      write_key(REG_KEY_HIGH, hi);
   endtask

   // Result side: stalls for a random number of cycles before each transfer, or
   // not at all during a steady stretch, and checks every ciphertext it takes.
   initial begin
      int gap;
      int taken;
      taken = 0;
      forever begin
         if (taken % 37 == 0) begin
            take_steady = ($urandom_range(0, 3) == 0);
         end
         gap = take_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1));
         ledger.check_ciphertext(rsp_tdata);
         taken++;
      end
   end

   // Watchdog: counts consecutive cycles without any transfer on any port.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Main sequence: directed blocks under the reset key, then the key extremes,
   // then random phases each under a fresh random key, then the reset key again.
   initial begin
      bit [BLOCK_WIDTH-1:0] corner [10];
      int                   sent;
      bit                   failed;

      corner = '{64'h0, {64{1'b1}}, {32{2'b01}}, {32{2'b10}}, 64'h8000_0000_0000_0000,
                 64'h1, 64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000,
                 64'h0123_4567_89ab_cdef, {$urandom, $urandom}};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key: the plaintext corners, back to back where the gap draws allow.
      foreach (corner[i]) begin
         send_plaintext(corner[i]);
      end

      // Key extremes: all zeros, all ones, and the two mixed halves. The drain in
      // load_keys is the point where the sender waits for every result.
      load_keys('0, '0);
      send_plaintext('0);
      send_plaintext({64{1'b1}});
      load_keys({64{1'b1}}, {64{1'b1}});
      send_plaintext('0);
      send_plaintext({64{1'b1}});
      load_keys('0, {64{1'b1}});
      send_plaintext({$urandom, $urandom});
      load_keys({64{1'b1}}, '0);
      send_plaintext({$urandom, $urandom});

      // Random phases. Each gets random key contents and random plaintexts; the
      // sender switches between idling and steady stretches every few dozen blocks.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_keys({$urandom, $urandom}, {$urandom, $urandom});
         for (sent = 0; sent < PHASE_ITEMS; sent++) begin
            if (sent % 40 == 0) begin
               send_steady = ($urandom_range(0, 2) == 0);
            end
            send_plaintext({$urandom, $urandom});
         end
      end

      // Back to the reset key values so the run ends on a known setting as well.
      load_keys(KEY_LOW_RESET, KEY_HIGH_RESET);
      send_plaintext({$urandom, $urandom});

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      failed = (ledger.errors != 0) || (ledger.owed() != 0);
      if (ledger.owed() != 0) begin
         $error("ciphertext: %0d expected results never arrived", ledger.owed());
      end
      if (!failed) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/gbe_pkg.sv
design/gbe_csr.sv
design/gbe_round.sv
design/granule_block_encrypt.sv
test/granule_block_encrypt_test.sv
